// ----- sv/mpfd_pkg.sv -----
// Package for the monochrome page frame store drawing engine.
// Holds screen geometry, command codes, memory request type and pixel helpers.
// No dependencies.
package mpfd_pkg;

   localparam int SCREEN_WIDTH  = 84;
   localparam int SCREEN_HEIGHT = 48;
   localparam int PAGE_COUNT    = 6;
   localparam int VIS_HEIGHT    = (SCREEN_HEIGHT < PAGE_COUNT * 8) ? SCREEN_HEIGHT
                                                                   : PAGE_COUNT * 8;
   localparam int STORE_DEPTH   = PAGE_COUNT * SCREEN_WIDTH;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int X_W           = $clog2(SCREEN_WIDTH);
   localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int COORD_W       = 18;
   localparam int DIFF_W        = 17;

   localparam logic signed [COORD_W-1:0] WIDTH_C  = COORD_W'(SCREEN_WIDTH);
   localparam logic signed [COORD_W-1:0] HEIGHT_C = COORD_W'(VIS_HEIGHT);

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_PIXEL  = 3'd1,
      CMD_READ   = 3'd2,
      CMD_VLINE  = 3'd3,
      CMD_HLINE  = 3'd4,
      CMD_FILL   = 3'd5,
      CMD_BORDER = 3'd6,
      CMD_LINE   = 3'd7
   } cmd_type;

   localparam logic [2:0] COLOR_CLEAR     = 3'd0;
   localparam logic [2:0] COLOR_SET       = 3'd1;
   localparam logic [2:0] COLOR_INVERT    = 3'd2;
   localparam logic [2:0] COLOR_OVERWRITE = 3'd4;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

   typedef struct packed {
      logic signed [15:0] x_a;
      logic signed [15:0] y_a;
      logic signed [15:0] x_b;
      logic signed [15:0] y_b;
      logic [2:0]         color;
      logic [2:0]         border_color;
      cmd_type            cmd;
   } draw_cmd_type;

   function automatic logic signed [COORD_W-1:0] widen(input logic signed [15:0] v);
      return COORD_W'(v);
   endfunction

   function automatic logic [DIFF_W-1:0] iabs(input logic signed [COORD_W-1:0] v);
      return (v < 0) ? DIFF_W'(-v) : DIFF_W'(v);
   endfunction

   function automatic logic [7:0] mask_span(input logic [2:0] lo, input logic [2:0] hi);
      logic [8:0] m;
      m = (9'd1 << ({1'b0, hi} + 4'd1)) - (9'd1 << lo);
      return m[7:0];
   endfunction

   function automatic logic [7:0] paint(input logic [7:0] old, input logic [7:0] mask,
                                        input logic [2:0] color);
      logic [7:0] r;
      r = old;
      case (color)
         COLOR_CLEAR:     r = old & ~mask;
         COLOR_SET:       r = old | mask;
         COLOR_INVERT:    r = old ^ mask;
         COLOR_OVERWRITE: r = mask;
         default:         r = old;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/mpfd_store.sv -----
// Frame store: one byte per column per page, synchronous (registered) read.
// Depends on mpfd_pkg.
module mpfd_store (
   input  logic                clock,
   input  mpfd_pkg::mem_req_type mem_req,
   output logic [7:0]          rdata
);

   logic [7:0] mem [mpfd_pkg::STORE_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/mpfd_engine.sv -----
// Command sequencer: clear sweep, rectangle passes, line stepping, pixel read.
// Every byte change but the clear sweep is a read-modify-write on mpfd_store. Depends on mpfd_pkg.
module mpfd_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mpfd_pkg::draw_cmd_type cmd_in,
   output logic                   idle,
   output logic                   done_valid,
   input  logic                   done_ack,
   output logic                   pixel_on,
   output logic [2:0]             done_cmd,
   output mpfd_pkg::mem_req_type  mem_req,
   input  logic [7:0]             mem_rdata
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SETUP, S_RD, S_WR, S_LINE_A, S_LINE_B,
      S_LPT, S_LWR, S_RSTART, S_RWAIT, S_DONE
   } state_type;

   localparam int CW = mpfd_pkg::COORD_W;
   localparam int DW = mpfd_pkg::DIFF_W;
   localparam int XW = mpfd_pkg::X_W;
   localparam int PW = mpfd_pkg::PAGE_W;
   localparam int AW = mpfd_pkg::ADDR_W;

   state_type              state_ff;
   mpfd_pkg::draw_cmd_type cmd_ff;
   mpfd_pkg::draw_cmd_type load_cmd_in;
   logic                   clr_cmd_ff;
   logic [AW-1:0]          clr_ff;
   logic [2:0]             pass_ff;
   logic                   plast_ff;
   logic [XW-1:0]          x_ff, x2_ff;
   logic [PW-1:0]          pg_ff, p1_ff, p2_ff;
   logic [2:0]             lo_ff, hi_ff, pcol_ff;
   logic                   steep_ff, yneg_ff, pixel_ff;
   logic signed [CW-1:0]   u1_ff, v1_ff, u2_ff, v2_ff;
   logic signed [CW-1:0]   cu_ff, cv_ff, uend_ff, err_ff;
   logic [DW-1:0]          dx_ff, dy_ff;

   // a pixel is a line with both end points equal
   always_comb begin
      load_cmd_in = cmd_in;
      if (cmd_in.cmd == mpfd_pkg::CMD_PIXEL) begin
         load_cmd_in.x_b = cmd_in.x_a;
         load_cmd_in.y_b = cmd_in.y_a;
      end
   end

   logic signed [CW-1:0] xa, ya, xb, yb;
   assign xa = mpfd_pkg::widen(cmd_ff.x_a);
   assign ya = mpfd_pkg::widen(cmd_ff.y_a);
   assign xb = mpfd_pkg::widen(cmd_ff.x_b);
   assign yb = mpfd_pkg::widen(cmd_ff.y_b);

   // pass setup: pick bounds, order, trim, clip
   logic signed [CW-1:0] ax1, ax2, ay1, ay2, sx1, sx2, sy1, sy2, cx1, cx2, cy1, cy2;
   logic [2:0]           pcol;
   logic                 tx, ty, pen, plast, pempty;

   always_comb begin
      ax1 = xa; ax2 = xb; ay1 = ya; ay2 = yb;
      pcol = cmd_ff.color; tx = 1'b0; ty = 1'b0; pen = 1'b1; plast = 1'b1;
      unique case (cmd_ff.cmd)
         mpfd_pkg::CMD_VLINE: begin
            ax2 = xa;
         end
         mpfd_pkg::CMD_HLINE: begin
            ay2 = ya;
         end
         mpfd_pkg::CMD_FILL: begin
         end
         mpfd_pkg::CMD_BORDER: begin
            pcol = cmd_ff.border_color;
            plast = 1'b0;
            pen = (cmd_ff.border_color < 3'd3);
            unique case (pass_ff)
               3'd0: begin
                  ay2 = ya; tx = 1'b1;
               end
               3'd1: begin
                  ay1 = yb; tx = 1'b1;
               end
               3'd2: begin
                  ax2 = xa; pen = (cmd_ff.border_color < 3'd3) && (ya != yb);
               end
               3'd3: begin
                  ax1 = xb; pen = (cmd_ff.border_color < 3'd3) && (ya != yb);
               end
               default: begin
                  pcol = cmd_ff.color; tx = 1'b1; ty = 1'b1; pen = 1'b1; plast = 1'b1;
               end
            endcase
         end
         default: begin
            pen = 1'b0;
         end
      endcase
      sx1 = ((ax1 < ax2) ? ax1 : ax2) + CW'(tx);
      sx2 = ((ax1 < ax2) ? ax2 : ax1) - CW'(tx);
      sy1 = ((ay1 < ay2) ? ay1 : ay2) + CW'(ty);
      sy2 = ((ay1 < ay2) ? ay2 : ay1) - CW'(ty);
      pempty = !pen || (pcol > 3'd2) || (sx1 > sx2) || (sy1 > sy2)
               || (sx1 >= mpfd_pkg::WIDTH_C) || (sx2 < 0)
               || (sy1 >= mpfd_pkg::HEIGHT_C) || (sy2 < 0);
      cx1 = (sx1 < 0) ? '0 : sx1;
      cx2 = (sx2 >= mpfd_pkg::WIDTH_C) ? mpfd_pkg::WIDTH_C - CW'(1) : sx2;
      cy1 = (sy1 < 0) ? '0 : sy1;
      cy2 = (sy2 >= mpfd_pkg::HEIGHT_C) ? mpfd_pkg::HEIGHT_C - CW'(1) : sy2;
   end

   // line setup
   logic [DW-1:0]        adx, ady, ldy;
   logic                 lsteep, lswap, lcol_ok;
   logic signed [CW-1:0] l_cu, l_cv, l_ue, l_ve;
   assign adx     = mpfd_pkg::iabs(xb - xa);
   assign ady     = mpfd_pkg::iabs(yb - ya);
   assign lsteep  = ady > adx;
   assign lcol_ok = (cmd_ff.color == mpfd_pkg::COLOR_CLEAR)
                 || (cmd_ff.color == mpfd_pkg::COLOR_SET)
                 || (cmd_ff.color == mpfd_pkg::COLOR_INVERT)
                 || (cmd_ff.color == mpfd_pkg::COLOR_OVERWRITE);
   assign lswap   = u1_ff > u2_ff;
   assign l_cu    = lswap ? u2_ff : u1_ff;
   assign l_cv    = lswap ? v2_ff : v1_ff;
   assign l_ue    = lswap ? u1_ff : u2_ff;
   assign l_ve    = lswap ? v1_ff : v2_ff;
   assign ldy     = mpfd_pkg::iabs(l_ve - l_cv);

   // line point and step
   logic signed [CW-1:0] px, py, err_step, err_next, cv_next;
   logic                 pon;
   assign px       = steep_ff ? cv_ff : cu_ff;
   assign py       = steep_ff ? cu_ff : cv_ff;
   assign pon      = (px >= 0) && (px < mpfd_pkg::WIDTH_C)
                  && (py >= 0) && (py < mpfd_pkg::HEIGHT_C);
   assign err_step = err_ff - $signed({1'b0, dy_ff});
   assign err_next = (err_step < 0) ? err_step + $signed({1'b0, dx_ff}) : err_step;
   assign cv_next  = (err_step < 0) ? (yneg_ff ? cv_ff - CW'(1) : cv_ff + CW'(1)) : cv_ff;

   logic rd_on;
   assign rd_on = (xa >= 0) && (xa < mpfd_pkg::WIDTH_C)
               && (ya >= 0) && (ya < mpfd_pkg::HEIGHT_C);

   // memory access
   logic [PW-1:0] a_pg;
   logic [XW-1:0] a_x;
   logic [7:0]    rmask;
   assign rmask = mpfd_pkg::mask_span((pg_ff == p1_ff) ? lo_ff : 3'd0,
                                      (pg_ff == p2_ff) ? hi_ff : 3'd7);

   always_comb begin
      a_pg = '0;
      a_x = '0;
      mem_req.we = 1'b0;
      mem_req.wdata = '0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_req.we = 1'b1;
         end
         S_RD, S_WR: begin
            a_pg = pg_ff;
            a_x = x_ff;
            mem_req.we = (state_ff == S_WR);
            mem_req.wdata = mpfd_pkg::paint(mem_rdata, rmask, pcol_ff);
         end
         S_LPT, S_LWR: begin
            a_pg = PW'(py[CW-1:3]);
            a_x = XW'(px);
            mem_req.we = (state_ff == S_LWR);
            mem_req.wdata = mpfd_pkg::paint(mem_rdata, 8'd1 << py[2:0], cmd_ff.color);
         end
         S_RSTART, S_RWAIT: begin
            a_pg = PW'(ya[CW-1:3]);
            a_x = XW'(xa);
         end
         default: begin
         end
      endcase
      mem_req.addr = (state_ff == S_CLEAR) ? clr_ff
                   : AW'(a_pg) * AW'(mpfd_pkg::SCREEN_WIDTH) + AW'(a_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         clr_cmd_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(mpfd_pkg::STORE_DEPTH - 1)) begin
                  state_ff <= clr_cmd_ff ? S_DONE : S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  cmd_ff   <= load_cmd_in;
                  pixel_ff <= 1'b0;
                  pass_ff  <= '0;
                  unique case (cmd_in.cmd)
                     mpfd_pkg::CMD_CLEAR: begin
                        clr_ff     <= '0;
                        clr_cmd_ff <= 1'b1;
                        state_ff   <= S_CLEAR;
                     end
                     mpfd_pkg::CMD_PIXEL: state_ff <= S_LINE_A;
                     mpfd_pkg::CMD_LINE:  state_ff <= S_LINE_A;
                     mpfd_pkg::CMD_READ:  state_ff <= S_RSTART;
                     default:             state_ff <= S_SETUP;
                  endcase
               end
            end
            S_SETUP: begin
               if (pempty) begin
                  pass_ff <= pass_ff + 3'd1;
                  if (plast) begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  x_ff     <= XW'(cx1);
                  x2_ff    <= XW'(cx2);
                  pg_ff    <= PW'(cy1[CW-1:3]);
                  p1_ff    <= PW'(cy1[CW-1:3]);
                  p2_ff    <= PW'(cy2[CW-1:3]);
                  lo_ff    <= cy1[2:0];
                  hi_ff    <= cy2[2:0];
                  pcol_ff  <= pcol;
                  plast_ff <= plast;
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_WR;
            S_WR: begin
               state_ff <= S_RD;
               if (pg_ff == p2_ff) begin
                  pg_ff <= p1_ff;
                  if (x_ff == x2_ff) begin
                     pass_ff  <= pass_ff + 3'd1;
                     state_ff <= plast_ff ? S_DONE : S_SETUP;
                  end else begin
                     x_ff <= x_ff + XW'(1);
                  end
               end else begin
                  pg_ff <= pg_ff + PW'(1);
               end
            end
            S_LINE_A: begin
               steep_ff <= lsteep;
               u1_ff    <= lsteep ? ya : xa;
               v1_ff    <= lsteep ? xa : ya;
               u2_ff    <= lsteep ? yb : xb;
               v2_ff    <= lsteep ? xb : yb;
               state_ff <= lcol_ok ? S_LINE_B : S_DONE;
            end
            S_LINE_B: begin
               cu_ff    <= l_cu;
               cv_ff    <= l_cv;
               uend_ff  <= l_ue;
               dx_ff    <= DW'(l_ue - l_cu);
               dy_ff    <= ldy;
               err_ff   <= $signed(CW'(DW'(l_ue - l_cu) >> 1));
               yneg_ff  <= !(l_cv < l_ve);
               state_ff <= S_LPT;
            end
            S_LPT, S_LWR: begin
               if (state_ff == S_LPT && pon) begin
                  state_ff <= S_LWR;
               end else begin
                  err_ff   <= err_next;
                  cv_ff    <= cv_next;
                  cu_ff    <= cu_ff + CW'(1);
                  state_ff <= (cu_ff == uend_ff) ? S_DONE : S_LPT;
               end
            end
            S_RSTART: state_ff <= rd_on ? S_RWAIT : S_DONE;
            S_RWAIT: begin
               pixel_ff <= mem_rdata[ya[2:0]];
               state_ff <= S_DONE;
            end
            S_DONE: begin
               clr_cmd_ff <= 1'b0;
               if (done_ack) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign idle       = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign pixel_on   = pixel_ff;
   assign done_cmd   = cmd_ff.cmd;

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> mem_req.addr < AW'(mpfd_pkg::STORE_DEPTH))
      else $error("frame store write beyond depth");

   a_rd_then_wr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |=> state_ff == S_WR)
      else $error("rect read not followed by write");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      done_valid && !done_ack |=> done_valid && $stable(pixel_on))
      else $error("result dropped before acknowledge");

   a_lwr_follows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LWR |-> $past(state_ff) == S_LPT)
      else $error("line write without read");

endmodule

// ----- sv/mono_page_framebuffer_draw.sv -----
// Top level of the monochrome page frame store drawing engine.
// Depends on mpfd_pkg, mpfd_store and mpfd_engine.
//
//   channel  direction  payload
//   req      in         tuser: cmd; tdata: x_a, y_a, x_b, y_b, color, border_color
//   rsp      out        tuser: done_cmd; tdata: pixel_on
//
// After reset a sweep zeroes all 504 store bytes; req_tready stays low meanwhile.
// Clear writes every byte in turn; a read addresses the byte of an on-screen pixel
// and then samples it; a rectangle pass has a setup state, then a read and write per
// byte touched; a line reads at each major-axis step and writes only visible points.
// One command is in work at a time; a finished result waits in the rsp register.
module mono_page_framebuffer_draw (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // x_a, y_a, x_b, y_b, color, border_color, zero pad
   input  logic [2:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pixel_on, zero pad
   output logic [2:0]  rsp_tuser    // done_cmd
);

   mpfd_pkg::draw_cmd_type cmd_in;
   mpfd_pkg::mem_req_type  mem_req;
   logic [7:0]             mem_rdata;
   logic                   idle, done_valid, slot_free, pixel_on;
   logic [2:0]             done_cmd;
   logic                   rsp_valid_ff, rsp_pixel_ff;
   logic [2:0]             rsp_cmd_ff;

   assign cmd_in.x_a          = req_tdata[15:0];
   assign cmd_in.y_a          = req_tdata[31:16];
   assign cmd_in.x_b          = req_tdata[47:32];
   assign cmd_in.y_b          = req_tdata[63:48];
   assign cmd_in.color        = req_tdata[66:64];
   assign cmd_in.border_color = req_tdata[69:67];
   assign cmd_in.cmd          = mpfd_pkg::cmd_type'(req_tuser);

   assign req_tready = idle;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   mpfd_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   mpfd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid && req_tready),
      .cmd_in     (cmd_in),
      .idle       (idle),
      .done_valid (done_valid),
      .done_ack   (slot_free),
      .pixel_on   (pixel_on),
      .done_cmd   (done_cmd),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_valid && slot_free) begin
         rsp_valid_ff <= 1'b1;
         rsp_pixel_ff <= pixel_on;
         rsp_cmd_ff   <= done_cmd;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_pixel_ff};
   assign rsp_tuser  = rsp_cmd_ff;

endmodule

// ----- bench/mpfd_checker.sv -----
`timescale 1ns / 100ps
// Checker for mono_page_framebuffer_draw: watches both channels, keeps a shadow frame store,
// predicts each response and compares it. Depends on mpfd_pkg.
module mpfd_checker
   import mpfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          mismatches,
   output int          outstanding
);

   typedef struct {
      logic       pixel_on;
      logic [2:0] done_cmd;
   } draw_result_type;

   logic [7:0]      shadow [STORE_DEPTH];
   draw_result_type expected_q [$];

   function automatic void put_mask(int page, int x, logic [7:0] m, logic [2:0] c);
      int idx;
      if (page < 0 || page >= PAGE_COUNT || x < 0 || x >= SCREEN_WIDTH) return;
      idx = page * SCREEN_WIDTH + x;
      case (c)
         COLOR_CLEAR:     shadow[idx] = shadow[idx] & ~m;
         COLOR_SET:       shadow[idx] = shadow[idx] | m;
         COLOR_INVERT:    shadow[idx] = shadow[idx] ^ m;
         COLOR_OVERWRITE: shadow[idx] = m;
         default: ;
      endcase
   endfunction

   function automatic bit visible(int x, int y);
      return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < VIS_HEIGHT;
   endfunction

   function automatic void plot(int x, int y, logic [2:0] c);
      if (visible(x, y)) put_mask(y / 8, x, 8'(1 << (y % 8)), c);
   endfunction

   function automatic void column(int x, int y1, int y2, logic [2:0] c);
      int t, lo, hi;
      if (c > 2 || x < 0 || x >= SCREEN_WIDTH) return;
      if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
      if (y1 >= VIS_HEIGHT || y2 < 0) return;
      if (y1 < 0) y1 = 0;
      if (y2 >= VIS_HEIGHT) y2 = VIS_HEIGHT - 1;
      for (int p = y1 / 8; p <= y2 / 8; p++) begin
         lo = (p == y1 / 8) ? y1 % 8 : 0;
         hi = (p == y2 / 8) ? y2 % 8 : 7;
         put_mask(p, x, 8'(((1 << (hi + 1)) - (1 << lo)) & 255), c);
      end
   endfunction

   function automatic void row(int y, int x1, int x2, logic [2:0] c, bit trim);
      int t;
      if (c > 2 || y < 0 || y >= VIS_HEIGHT) return;
      if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
      if (trim) begin
         x1++; x2--;
         if (x1 > x2) return;
      end
      if (x1 >= SCREEN_WIDTH || x2 < 0) return;
      if (x1 < 0) x1 = 0;
      if (x2 >= SCREEN_WIDTH) x2 = SCREEN_WIDTH - 1;
      for (int x = x1; x <= x2; x++) put_mask(y / 8, x, 8'(1 << (y % 8)), c);
   endfunction

   function automatic void area(int x1, int y1, int x2, int y2, logic [2:0] c, bit trim);
      int t;
      if (c > 2) return;
      if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
      if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
      if (trim) begin
         x1++; x2--; y1++; y2--;
         if (x1 > x2 || y1 > y2) return;
      end
      if (x1 >= SCREEN_WIDTH || x2 < 0 || y1 >= VIS_HEIGHT || y2 < 0) return;
      if (x1 < 0) x1 = 0;
      if (x2 >= SCREEN_WIDTH) x2 = SCREEN_WIDTH - 1;
      for (int x = x1; x <= x2; x++) column(x, y1, y2, c);
   endfunction

   function automatic void segment(int x1, int y1, int x2, int y2, logic [2:0] c);
      bit steep;
      int t, dx, dy, err, ystep;
      steep = ((y2 > y1) ? y2 - y1 : y1 - y2) > ((x2 > x1) ? x2 - x1 : x1 - x2);
      if (steep) begin
         t = x1; x1 = y1; y1 = t;
         t = x2; x2 = y2; y2 = t;
      end
      if (x1 > x2) begin
         t = x1; x1 = x2; x2 = t;
         t = y1; y1 = y2; y2 = t;
      end
      dx = x2 - x1;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      err = dx / 2;
      ystep = (y1 < y2) ? 1 : -1;
      for (; x1 <= x2; x1++) begin
         if (steep) plot(y1, x1, c);
         else plot(x1, y1, c);
         err -= dy;
         if (err < 0) begin
            y1 += ystep;
            err += dx;
         end
      end
   endfunction

   function automatic draw_result_type run_command(logic [2:0] op, logic [71:0] d);
      draw_result_type r;
      int xa, ya, xb, yb;
      logic [2:0] c, bc;
      xa = $signed(d[15:0]);
      ya = $signed(d[31:16]);
      xb = $signed(d[47:32]);
      yb = $signed(d[63:48]);
      c  = d[66:64];
      bc = d[69:67];
      r.pixel_on = 1'b0;
      r.done_cmd = op;
      case (cmd_type'(op))
         CMD_CLEAR: foreach (shadow[i]) shadow[i] = 8'h00;
         CMD_PIXEL: plot(xa, ya, c);
         CMD_READ:  if (visible(xa, ya)) r.pixel_on = shadow[(ya / 8) * SCREEN_WIDTH + xa][ya % 8];
         CMD_VLINE: column(xa, ya, yb, c);
         CMD_HLINE: row(ya, xa, xb, c, 1'b0);
         CMD_FILL:  area(xa, ya, xb, yb, c, 1'b0);
         CMD_BORDER: begin
            if (bc < 3) begin
               row(ya, xa, xb, bc, 1'b1);
               row(yb, xa, xb, bc, 1'b1);
               if (ya != yb) begin
                  column(xa, ya, yb, bc);
                  column(xb, ya, yb, bc);
               end
            end
            area(xa, ya, xb, yb, c, 1'b1);
         end
         default: segment(xa, ya, xb, yb, c);
      endcase
      return r;
   endfunction

   assign outstanding = expected_q.size();

   always @(posedge clock) begin
      draw_result_type want;
      if (reset) begin
         foreach (shadow[i]) shadow[i] <= 8'h00;
         mismatches <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_q.push_back(run_command(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected response cmd=%0d pixel=%0b", $realtime,
                           rsp_tuser, rsp_tdata[0]);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.pixel_on !== rsp_tdata[0] || want.done_cmd !== rsp_tuser
                   || rsp_tdata[7:1] !== 7'd0) begin
                  if (mismatches < 10)
                     $display("%0t: cmd exp %0d got %0d, pixel exp %0b got %0b (tdata %h)",
                              $realtime, want.done_cmd, rsp_tuser, want.pixel_on,
                              rsp_tdata[0], rsp_tdata);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the drawing engine bench: clock, reset, command stimulus, response stalls, verdict.
// Depends on mpfd_pkg, mpfd_checker and mono_page_framebuffer_draw.
module tb_top;
   import mpfd_pkg::*;

   localparam int IDLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   int          mismatches;
   int          outstanding;
   int          idle_cycles;
   int          burst_left;
   int          stall_mode;

   mono_page_framebuffer_draw u_dut (.*);

   mpfd_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // stall pattern: runs of always-ready, random, and mostly-stalled
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic issue(cmd_type op, int xa, int ya, int xb, int yb, int c, int bc);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, 3'(bc), 3'(c), 16'(yb), 16'(xb), 16'(ya), 16'(xa)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   function automatic int pick_coord(bit cheap);
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(0, 110) - 12;
      if (r < 97 || cheap) return $urandom_range(0, 500) - 200;
      return $signed(16'($urandom));
   endfunction

   initial begin
      int op, xa, ya, xb, yb;
      bit cheap;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      burst_left = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      issue(CMD_READ, 0, 0, 0, 0, 0, 0);
      issue(CMD_PIXEL, 0, 0, 0, 0, COLOR_SET, 0);
      issue(CMD_PIXEL, 83, 47, 0, 0, COLOR_SET, 0);
      issue(CMD_PIXEL, 84, 48, 0, 0, COLOR_SET, 0);
      issue(CMD_PIXEL, -1, 5, 0, 0, COLOR_SET, 0);
      issue(CMD_PIXEL, 10, 10, 0, 0, COLOR_OVERWRITE, 0);
      issue(CMD_READ, 83, 47, 0, 0, 0, 0);
      issue(CMD_READ, 32767, -32768, 0, 0, 0, 0);
      issue(CMD_VLINE, 5, -32768, 32767, 0, COLOR_SET, 0);
      issue(CMD_VLINE, 6, 30, 3, 0, COLOR_OVERWRITE, 0);
      issue(CMD_HLINE, 32767, 20, -32768, 0, COLOR_INVERT, 0);
      issue(CMD_FILL, -32768, -32768, 32767, 32767, COLOR_INVERT, 0);
      issue(CMD_FILL, 10, 3, 20, 12, COLOR_CLEAR, 0);
      issue(CMD_BORDER, 2, 5, 30, 5, COLOR_SET, COLOR_INVERT);
      issue(CMD_BORDER, 40, 2, 40, 40, COLOR_INVERT, COLOR_SET);
      issue(CMD_BORDER, 50, 1, 80, 46, COLOR_SET, COLOR_CLEAR);
      issue(CMD_BORDER, -5, -5, 100, 60, 7, 3);
      issue(CMD_LINE, 0, 0, 83, 20, COLOR_INVERT, 0);
      issue(CMD_LINE, 70, 47, 60, 0, COLOR_SET, 0);
      issue(CMD_LINE, 20, 20, 20, 20, COLOR_OVERWRITE, 0);
      issue(CMD_LINE, -32768, 32767, 32767, -32768, COLOR_INVERT, 0);
      issue(CMD_READ, 20, 20, 0, 0, 0, 0);
      issue(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      issue(CMD_READ, 83, 47, 0, 0, 0, 0);

      repeat (1300) begin
         op = $urandom_range(0, 99);
         if (op < 2)       op = CMD_CLEAR;
         else if (op < 25) op = CMD_READ;
         else if (op < 45) op = CMD_PIXEL;
         else              op = $urandom_range(CMD_VLINE, CMD_LINE);
         cheap = (op == CMD_LINE) && ($urandom_range(0, 299) != 0);
         xa = pick_coord(cheap);
         ya = pick_coord(cheap);
         xb = pick_coord(cheap);
         yb = pick_coord(cheap);
         issue(cmd_type'(op), xa, ya, xb, yb, $urandom_range(0, 7), $urandom_range(0, 7));
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/mpfd_pkg.sv
sv/mpfd_store.sv
sv/mpfd_engine.sv
sv/mono_page_framebuffer_draw.sv
bench/mpfd_checker.sv
bench/tb_top.sv
